// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PRG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/prg_pkg.sv -----
// ----------------------------------------------------------------------------
// prg_pkg
// Widths, register indexes and the microcode program of the PID step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prg_pkg;

    localparam int IN_W       = 24;
    localparam int ERR_W      = 25;
    localparam int ERR2_W     = 26;
    localparam int GAIN_W     = 16;
    localparam int DT_W       = 16;
    localparam int DVSR_W     = 32;
    localparam int OUT_W      = 32;
    localparam int SUM_W      = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P_NUM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_DEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_I_NUM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_I_DEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_D_NUM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_D_DEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd6;

    // Saturation limits
    localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 34'sh3_8000_0000;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_ERR,
        ACT_MUL_INC,
        ACT_ACC_INC,
        ACT_MUL_P,
        ACT_MUL_I,
        ACT_MUL_DDEN,
        ACT_MUL_D,
        ACT_DIV_START,
        ACT_DIV_STEP,
        ACT_ADD_TERM,
        ACT_FINISH
    } t_act;

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_INPUT,
        HOLD_DIV_BUSY,
        HOLD_OUT_BUSY
    } t_hold;

    typedef struct packed {
        t_act  act;
        t_hold hold;
        logic  jump;
        t_step target;
    } t_uword;

    // Program steps
    localparam t_step STEP_IDLE    = 5'd0;
    localparam t_step STEP_ERR     = 5'd1;
    localparam t_step STEP_INC_MUL = 5'd2;
    localparam t_step STEP_INC_ACC = 5'd3;
    localparam t_step STEP_P_MUL   = 5'd4;
    localparam t_step STEP_P_LOAD  = 5'd5;
    localparam t_step STEP_P_DIV   = 5'd6;
    localparam t_step STEP_P_ADD   = 5'd7;
    localparam t_step STEP_I_MUL   = 5'd8;
    localparam t_step STEP_I_LOAD  = 5'd9;
    localparam t_step STEP_I_DIV   = 5'd10;
    localparam t_step STEP_I_ADD   = 5'd11;
    localparam t_step STEP_D_DEN   = 5'd12;
    localparam t_step STEP_D_MUL   = 5'd13;
    localparam t_step STEP_D_LOAD  = 5'd14;
    localparam t_step STEP_D_DIV   = 5'd15;
    localparam t_step STEP_D_ADD   = 5'd16;
    localparam t_step STEP_FINISH  = 5'd17;

    function automatic t_uword ucode_rom(input t_step pc);
        t_uword uw;
        uw = '{act: ACT_NOP, hold: HOLD_NONE, jump: 1'b0, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE: begin
                uw.act  = ACT_ACCEPT;
                uw.hold = HOLD_NO_INPUT;
            end
            STEP_ERR:     uw.act = ACT_ERR;
            STEP_INC_MUL: uw.act = ACT_MUL_INC;
            STEP_INC_ACC: uw.act = ACT_ACC_INC;
            STEP_P_MUL:   uw.act = ACT_MUL_P;
            STEP_P_LOAD:  uw.act = ACT_DIV_START;
            STEP_P_DIV: begin
                uw.act  = ACT_DIV_STEP;
                uw.hold = HOLD_DIV_BUSY;
            end
            STEP_P_ADD:   uw.act = ACT_ADD_TERM;
            STEP_I_MUL:   uw.act = ACT_MUL_I;
            STEP_I_LOAD:  uw.act = ACT_DIV_START;
            STEP_I_DIV: begin
                uw.act  = ACT_DIV_STEP;
                uw.hold = HOLD_DIV_BUSY;
            end
            STEP_I_ADD:   uw.act = ACT_ADD_TERM;
            STEP_D_DEN:   uw.act = ACT_MUL_DDEN;
            STEP_D_MUL:   uw.act = ACT_MUL_D;
            STEP_D_LOAD:  uw.act = ACT_DIV_START;
            STEP_D_DIV: begin
                uw.act  = ACT_DIV_STEP;
                uw.hold = HOLD_DIV_BUSY;
            end
            STEP_D_ADD:   uw.act = ACT_ADD_TERM;
            STEP_FINISH: begin
                uw.act  = ACT_FINISH;
                uw.hold = HOLD_OUT_BUSY;
                uw.jump = 1'b1;
            end
            default: begin
                uw.jump = 1'b1;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pid_rational_gain_step_unit.sv -----
// ----------------------------------------------------------------------------
// pid_rational_gain_step_unit
// Integer PID controller step with a trapezoidal integral and rational gains.
// ----------------------------------------------------------------------------
// Each input transfer carries a setpoint, a measurement and a time step and
// yields exactly one drive value. The error is setpoint minus measurement.
// When the magnitude of the error exceeds the deadband, the running integral
// gains time step times the sum of this and the previous error, halved and
// truncated toward zero; the integral wraps at DATA_WIDTH bits. The P, I and
// D terms are each a full-width product divided by a configured denominator
// (the D divisor also includes the time step), truncated toward zero and
// saturated to 32-bit signed, and their sum saturates again. A zero divisor
// gives a zero term. The unit is driven by a small microcode program held in
// a read-only table: each step selects one action of a shared datapath made
// of one multiplier and one restoring divider that retires one quotient bit
// per cycle. Most of the time that one item occupies the unit is spent in
// its three passes through the divider, each yielding PROD_W quotient
// bits, where PROD_W = max(DATA_WIDTH, 26) + 16. The input is stalled for
// all of that time except in the idle step of the program, in which the
// next transfer is taken, while a finished result waits in the output
// register and does not hold back the next transfer until the next result
// is ready to be written. Configuration is written through a plain write
// port and must only change while the unit is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_rational_gain_step_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_wr_en,
    input  logic [prg_pkg::CFG_IDX_W-1:0]       i_wr_index,
    input  logic [prg_pkg::CFG_DATA_W-1:0]      i_wr_data,
    // Input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [prg_pkg::IN_W-1:0]     i_setpoint,
    input  logic signed [prg_pkg::IN_W-1:0]     i_measured,
    input  logic [prg_pkg::DT_W-1:0]            i_time_step,
    // Output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [prg_pkg::OUT_W-1:0]    o_drive
);

    // Magnitude operand of the shared multiplier: wide enough for the
    // integral and for the 26-bit error sums.
    localparam int MAG_W  = (DATA_WIDTH > 26) ? DATA_WIDTH : 26;
    localparam int PROD_W = MAG_W + 16;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int EXT_W  = (DATA_WIDTH > 42) ? DATA_WIDTH : 42;

    localparam logic [PROD_W-1:0] Q_POS_LIM = PROD_W'(32'h7FFF_FFFF);
    localparam logic [PROD_W-1:0] Q_NEG_LIM = PROD_W'(32'h8000_0000);

    // Configuration registers
    logic [15:0] r_p_num, r_p_den, r_i_num, r_i_den, r_d_num, r_d_den, r_deadband;

    // Sequencer
    prg_pkg::t_step  r_pc, n_pc;
    prg_pkg::t_uword uword;
    logic            hold;
    logic            in_xfer;
    logic            out_busy;
    logic            div_busy;

    // Controller state
    logic [DATA_WIDTH-1:0] r_error_sum;
    logic [24:0]           r_prev;

    // Datapath
    logic [23:0]           r_setpoint, r_measured;
    logic [15:0]           r_dt;
    logic [24:0]           r_err;
    logic                  r_pass;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_neg;
    logic [31:0]           r_divisor;
    logic [PROD_W-1:0]     r_quo;
    logic [31:0]           r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [33:0]    r_sum;
    logic                  r_out_valid;
    logic [31:0]           r_drive;

    // Arithmetic helpers
    logic [25:0]           err_add, err_diff, add_mag, diff_mag;
    logic [24:0]           err_mag;
    logic [15:0]           p_mag, i_mag, d_mag;
    logic [DATA_WIDTH-1:0] sum_mag;
    logic [MAG_W-1:0]      mul_a;
    logic [15:0]           mul_b;
    logic                  mul_neg;
    logic [PROD_W-1:0]     mul_p;
    logic [32:0]           rem_sh;
    logic [33:0]           trial;
    logic                  ge;
    logic signed [31:0]    term;
    logic [EXT_W-1:0]      inc;
    logic [31:0]           drive_sat;

    // ------------------------------------------------------------------
    // Sequencer: the control word of the current step decides the action,
    // whether the step repeats and where the program goes next.
    // ------------------------------------------------------------------
    assign uword    = prg_pkg::ucode_rom(r_pc);
    assign o_stall  = (r_pc != prg_pkg::STEP_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_busy = r_out_valid && i_stall;
    assign div_busy = (r_cnt != CNT_W'(1));

    always_comb begin
        unique case (uword.hold)
            prg_pkg::HOLD_NONE:     hold = 1'b0;
            prg_pkg::HOLD_NO_INPUT: hold = !i_valid;
            prg_pkg::HOLD_DIV_BUSY: hold = div_busy;
            prg_pkg::HOLD_OUT_BUSY: hold = out_busy;
            default:                hold = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (uword.jump) begin
            n_pc = uword.target;
        end else begin
            n_pc = r_pc + prg_pkg::t_step'(1);
        end
    end

    // ------------------------------------------------------------------
    // Operand magnitudes. The multiplier and divider work on magnitudes and
    // the sign of each product is carried alongside in r_neg.
    // ------------------------------------------------------------------
    assign err_add  = {r_err[24], r_err} + {r_prev[24], r_prev};
    assign err_diff = {r_err[24], r_err} - {r_prev[24], r_prev};
    assign add_mag  = err_add[25]  ? -err_add  : err_add;
    assign diff_mag = err_diff[25] ? -err_diff : err_diff;
    assign err_mag  = r_err[24]    ? -r_err    : r_err;
    assign p_mag    = r_p_num[15]  ? -r_p_num  : r_p_num;
    assign i_mag    = r_i_num[15]  ? -r_i_num  : r_i_num;
    assign d_mag    = r_d_num[15]  ? -r_d_num  : r_d_num;
    assign sum_mag  = r_error_sum[DATA_WIDTH-1] ? -r_error_sum : r_error_sum;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (uword.act)
            prg_pkg::ACT_MUL_INC: begin
                mul_a   = MAG_W'(add_mag);
                mul_b   = r_dt;
                mul_neg = err_add[25];
            end
            prg_pkg::ACT_MUL_P: begin
                mul_a   = MAG_W'(err_mag);
                mul_b   = p_mag;
                mul_neg = r_err[24] ^ r_p_num[15];
            end
            prg_pkg::ACT_MUL_I: begin
                mul_a   = MAG_W'(sum_mag);
                mul_b   = i_mag;
                mul_neg = r_error_sum[DATA_WIDTH-1] ^ r_i_num[15];
            end
            prg_pkg::ACT_MUL_DDEN: begin
                mul_a   = MAG_W'(r_d_den);
                mul_b   = r_dt;
            end
            prg_pkg::ACT_MUL_D: begin
                mul_a   = MAG_W'(diff_mag);
                mul_b   = d_mag;
                mul_neg = err_diff[25] ^ r_d_num[15];
            end
            default: begin
                mul_a   = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Restoring division, one quotient bit per step.
    assign rem_sh = {r_rem, r_quo[PROD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_divisor};
    assign ge     = !trial[33];

    // Signed, saturated quotient of the term just divided.
    always_comb begin
        if (r_divisor == '0) begin
            term = '0;
        end else if (r_neg) begin
            term = (r_quo > Q_NEG_LIM) ? prg_pkg::OUT_MIN : -r_quo[31:0];
        end else begin
            term = (r_quo > Q_POS_LIM) ? prg_pkg::OUT_MAX : r_quo[31:0];
        end
    end

    // Trapezoid increment: halving the magnitude truncates toward zero.
    assign inc = r_neg ? -EXT_W'(r_prod[41:1]) : EXT_W'(r_prod[41:1]);

    always_comb begin
        if (r_sum > prg_pkg::SUM_MAX) begin
            drive_sat = prg_pkg::OUT_MAX;
        end else if (r_sum < prg_pkg::SUM_MIN) begin
            drive_sat = prg_pkg::OUT_MIN;
        end else begin
            drive_sat = r_sum[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Control and controller state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= prg_pkg::STEP_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_error_sum <= '0;
            r_prev      <= '0;
            r_p_num     <= 16'd0;
            r_p_den     <= 16'd1;
            r_i_num     <= 16'd0;
            r_i_den     <= 16'd1;
            r_d_num     <= 16'd0;
            r_d_den     <= 16'd1;
            r_deadband  <= 16'd0;
        end else begin
            r_pc <= n_pc;

            if (i_wr_en) begin
                unique case (i_wr_index)
                    prg_pkg::REG_P_NUM:    r_p_num    <= i_wr_data;
                    prg_pkg::REG_P_DEN:    r_p_den    <= i_wr_data;
                    prg_pkg::REG_I_NUM:    r_i_num    <= i_wr_data;
                    prg_pkg::REG_I_DEN:    r_i_den    <= i_wr_data;
                    prg_pkg::REG_D_NUM:    r_d_num    <= i_wr_data;
                    prg_pkg::REG_D_DEN:    r_d_den    <= i_wr_data;
                    prg_pkg::REG_DEADBAND: r_deadband <= i_wr_data;
                    default: ;
                endcase
            end

            // A new result may replace one that leaves in the same cycle.
            if ((uword.act == prg_pkg::ACT_FINISH) && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (uword.act)
                prg_pkg::ACT_ACC_INC: begin
                    if (r_pass) begin
                        r_error_sum <= r_error_sum + inc[DATA_WIDTH-1:0];
                    end
                end
                prg_pkg::ACT_DIV_START: r_cnt <= CNT_W'(PROD_W);
                prg_pkg::ACT_DIV_STEP:  r_cnt <= r_cnt - CNT_W'(1);
                prg_pkg::ACT_FINISH: begin
                    if (!out_busy) begin
                        r_prev <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (uword.act)
            prg_pkg::ACT_ACCEPT: begin
                if (in_xfer) begin
                    r_setpoint <= i_setpoint;
                    r_measured <= i_measured;
                    r_dt       <= i_time_step;
                    r_sum      <= '0;
                end
            end
            prg_pkg::ACT_ERR: begin
                r_err <= {r_setpoint[23], r_setpoint} - {r_measured[23], r_measured};
            end
            prg_pkg::ACT_MUL_INC: begin
                r_prod <= mul_p;
                r_neg  <= mul_neg;
                r_pass <= (err_mag > 25'(r_deadband));
            end
            prg_pkg::ACT_MUL_P: begin
                r_prod    <= mul_p;
                r_neg     <= mul_neg;
                r_divisor <= 32'(r_p_den);
            end
            prg_pkg::ACT_MUL_I: begin
                r_prod    <= mul_p;
                r_neg     <= mul_neg;
                r_divisor <= 32'(r_i_den);
            end
            prg_pkg::ACT_MUL_DDEN: begin
                r_divisor <= mul_p[31:0];
            end
            prg_pkg::ACT_MUL_D: begin
                r_prod <= mul_p;
                r_neg  <= mul_neg;
            end
            prg_pkg::ACT_DIV_START: begin
                r_quo <= r_prod;
                r_rem <= '0;
            end
            prg_pkg::ACT_DIV_STEP: begin
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_rem <= ge ? trial[31:0] : rem_sh[31:0];
            end
            prg_pkg::ACT_ADD_TERM: begin
                r_sum <= r_sum + 34'(term);
            end
            prg_pkg::ACT_FINISH: begin
                if (!out_busy) begin
                    r_drive <= drive_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

endmodule

`default_nettype wire

// ----- sv/prg_port_checker.sv -----
// ----------------------------------------------------------------------------
// prg_port_checker
// Port-level checks of the PID step unit, attached to it by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module prg_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_drive
);

    // Reset leaves the unit ready for input with no result pending.
    `PRG_ASSERT_ALWAYS(a_reset_clean, i_clk, !i_rst_n |=> !o_valid && !o_stall, "unit not clean after reset")

    // An accepted item keeps the input stalled while it is worked on.
    `PRG_ASSERT(a_busy_after_in, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall ##1 o_stall, "input not stalled while busy")

    // No result can appear in the cycle straight after an input transfer.
    `PRG_ASSERT(a_no_early_out, i_clk, i_rst_n, i_valid && !o_stall |=> !$rose(o_valid), "result appeared too early")

    // A stalled result stays put.
    `PRG_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_drive), "stalled result changed")

endmodule

bind pid_rational_gain_step_unit prg_port_checker u_prg_port_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_drive (o_drive)
);

`default_nettype wire

// ----- test/pid_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the configuration port and both channels of the PID step unit,
// predicts each drive value from its own copy of the gains, the integral and
// the previous error, and compares every output transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------

module pid_drive_checker
    import prg_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_wr_index,
    input  logic [CFG_DATA_W-1:0]       i_wr_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [IN_W-1:0]      i_setpoint,
    input  logic signed [IN_W-1:0]      i_measured,
    input  logic [DT_W-1:0]             i_time_step,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [OUT_W-1:0]     i_drive,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);

    localparam int SUM_BITS = 32;

    logic signed [GAIN_W-1:0]   p_num;
    logic signed [GAIN_W-1:0]   i_num;
    logic signed [GAIN_W-1:0]   d_num;
    logic        [GAIN_W-1:0]   p_den;
    logic        [GAIN_W-1:0]   i_den;
    logic        [GAIN_W-1:0]   d_den;
    logic        [GAIN_W-1:0]   deadband;
    logic signed [SUM_BITS-1:0] integ;
    longint                     last_err;
    logic signed [OUT_W-1:0]    drive_due_q[$];
    int                         mismatches = 0;
    int                         waiting    = 0;
    int                         results    = 0;

    assign o_fail_count   = mismatches;
    assign o_pending      = waiting;
    assign o_result_count = results;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic longint clamp_drive(input longint v);
        if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
        if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
        return v;
    endfunction

    // One controller step: updates the integral and the previous error.
    function automatic logic signed [OUT_W-1:0] step_drive(
        input logic signed [IN_W-1:0] sp,
        input logic signed [IN_W-1:0] pv,
        input logic [DT_W-1:0]        dt
    );
        longint err, mag, dt_l, inc, d_div;
        longint p_term, i_term, d_term;
        err  = longint'(sp) - longint'(pv);
        mag  = (err < 0) ? -err : err;
        dt_l = longint'(dt);
        if (mag > longint'(deadband)) begin
            // Trapezoid, halved with truncation toward zero; the integral wraps.
            inc   = (dt_l * (err + last_err)) / 2;
            integ = integ + SUM_BITS'(inc);
        end
        p_term = 0;
        i_term = 0;
        d_term = 0;
        if (p_den != 0) begin
            p_term = clamp_drive((longint'(p_num) * err) / longint'(p_den));
        end
        if (i_den != 0) begin
            i_term = clamp_drive((longint'(integ) * longint'(i_num)) / longint'(i_den));
        end
        d_div = longint'(d_den) * dt_l;
        if (d_div != 0) begin
            d_term = clamp_drive((longint'(d_num) * (err - last_err)) / d_div);
        end
        last_err = err;
        return OUT_W'(clamp_drive(p_term + i_term + d_term));
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [OUT_W-1:0] due;
        if (!i_rst_n) begin
            p_num    = '0;
            p_den    = GAIN_W'(1);
            i_num    = '0;
            i_den    = GAIN_W'(1);
            d_num    = '0;
            d_den    = GAIN_W'(1);
            deadband = '0;
            integ    = '0;
            last_err = 0;
            drive_due_q.delete();
        end else begin
            // Output first: a result leaving now never belongs to a step entering now.
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (drive_due_q.size() == 0) begin
                    report_mismatch($sformatf("drive %0d arrived with no step waiting",
                                              i_drive));
                end else begin
                    due = drive_due_q.pop_front();
                    if (i_drive !== due) begin
                        report_mismatch($sformatf("result %0d: drive %0d, expected %0d",
                                                  results, i_drive, due));
                    end
                end
            end
            if (i_wr_en) begin
                case (i_wr_index)
                    REG_P_NUM:    p_num    = i_wr_data;
                    REG_P_DEN:    p_den    = i_wr_data;
                    REG_I_NUM:    i_num    = i_wr_data;
                    REG_I_DEN:    i_den    = i_wr_data;
                    REG_D_NUM:    d_num    = i_wr_data;
                    REG_D_DEN:    d_den    = i_wr_data;
                    REG_DEADBAND: deadband = i_wr_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                drive_due_q.push_back(step_drive(i_setpoint, i_measured, i_time_step));
            end
        end
        waiting = drive_due_q.size();
    end

endmodule

// ----- test/pid_rational_gain_step_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_rational_gain_step_unit_tb
// Regression bench for the PID step unit: a short directed part at the field
// and gain extremes, then random steps over many gain settings, with random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------

module pid_rational_gain_step_unit_tb;

    import prg_pkg::*;

    // Timing. LATENCY is the time that one step occupies the unit at the
    // default integral width; it sets the final settling wait below.
    localparam int     CLK_HALF     = 4;
    localparam int     LATENCY      = 3 * (32 + 16) + 15;
    localparam int     RX_LONG_HOLD = 2000;
    localparam longint TIMEOUT_NS   = 64_000_000;

    // Random part: gain settings and steps per setting.
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 150;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic signed [IN_W-1:0] IN_MAX  = 24'sh7F_FFFF;
    localparam logic signed [IN_W-1:0] IN_MIN  = 24'sh80_0000;
    localparam logic [GAIN_W-1:0]      NUM_MAX = 16'h7FFF;
    localparam logic [GAIN_W-1:0]      NUM_MIN = 16'h8000;
    localparam logic [GAIN_W-1:0]      DEN_MAX = 16'hFFFF;
    localparam logic [DT_W-1:0]        DT_MAX  = 16'hFFFF;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]    wr_index    = '0;
    logic [CFG_DATA_W-1:0]   wr_data     = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic signed [IN_W-1:0]  setpoint    = '0;
    logic signed [IN_W-1:0]  measured    = '0;
    logic [DT_W-1:0]         time_step   = DT_W'(1);
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic signed [OUT_W-1:0] drive;

    logic rx_hold_req  = 1'b0;
    int   fail_count;
    int   pending;
    int   result_count;
    int   burst_left   = 0;
    int   gain_settings = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    pid_rational_gain_step_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_wr_en     (wr_en),
        .i_wr_index  (wr_index),
        .i_wr_data   (wr_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_setpoint  (setpoint),
        .i_measured  (measured),
        .i_time_step (time_step),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_drive     (drive)
    );

    pid_drive_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_wr_en        (wr_en),
        .i_wr_index     (wr_index),
        .i_wr_data      (wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_setpoint     (setpoint),
        .i_measured     (measured),
        .i_time_step    (time_step),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_drive        (drive),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Idle time after a transfer. Mostly back-to-back, now and then a burst
    // with no gaps at all, and a few long pauses so that the next transfer
    // lands at every point of the unit's internal program.
    task automatic pace_sender();
        int r;
        int gap;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                burst_left = $urandom_range(10, 40);
            end else if (r < 55) begin
                gap = 0;
            end else if (r < 88) begin
                gap = $urandom_range(1, 8);
            end else if (r < 98) begin
                gap = $urandom_range(9, 200);
            end else begin
                gap = $urandom_range(201, 600);
            end
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offers one step and holds the payload steady until the transfer happens.
    // Valid stays high unless pace_sender draws a gap, so steps can go straight on.
    task automatic send_step(
        input logic signed [IN_W-1:0] sp,
        input logic signed [IN_W-1:0] pv,
        input logic [DT_W-1:0]        dt
    );
        in_valid  <= 1'b1;
        setpoint  <= sp;
        measured  <= pv;
        time_step <= dt;
        do @(posedge clk); while (in_stall);
        pace_sender();
    endtask

    // Stops offering and waits until every predicted drive value has been
    // seen. The count is read on the falling edge, clear of the update that
    // the checker makes on the rising one.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] data
    );
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Writes the full register set back to back; only called while idle.
    task automatic program_gains(
        input logic [GAIN_W-1:0] pn, input logic [GAIN_W-1:0] pd,
        input logic [GAIN_W-1:0] in, input logic [GAIN_W-1:0] id,
        input logic [GAIN_W-1:0] dn, input logic [GAIN_W-1:0] dd,
        input logic [GAIN_W-1:0] db
    );
        write_reg(REG_P_NUM, pn);
        write_reg(REG_P_DEN, pd);
        write_reg(REG_I_NUM, in);
        write_reg(REG_I_DEN, id);
        write_reg(REG_D_NUM, dn);
        write_reg(REG_D_DEN, dd);
        write_reg(REG_DEADBAND, db);
        wr_en <= 1'b0;
        gain_settings++;
    endtask

    function automatic logic [GAIN_W-1:0] rand_num();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return GAIN_W'($urandom_range(0, 16) - 8);
        if (r < 75) return GAIN_W'($urandom);
        if (r < 87) return NUM_MAX;
        return NUM_MIN;
    endfunction

    function automatic logic [GAIN_W-1:0] rand_den();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return GAIN_W'($urandom_range(1, 16));
        if (r < 80) return GAIN_W'($urandom_range(1, 65535));
        if (r < 90) return GAIN_W'(1);
        return DEN_MAX;
    endfunction

    task automatic random_gains();
        int                r;
        logic [GAIN_W-1:0] db;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            db = '0;
        end else if (r < 60) begin
            db = GAIN_W'($urandom_range(0, 255));
        end else if (r < 90) begin
            db = GAIN_W'($urandom);
        end else begin
            db = DEN_MAX;
        end
        program_gains(rand_num(), rand_den(), rand_num(), rand_den(),
                      rand_num(), rand_den(), db);
    endtask

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return IN_MAX;
            1:       return IN_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_time_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return DT_W'($urandom_range(1, 64));
        if (r < 88) return DT_W'($urandom_range(1, 65535));
        return DT_MAX;
    endfunction

    // A random step. Besides fully random values, errors close to the
    // deadband, small signals that keep the terms out of saturation and the
    // range extremes are all mixed in.
    task automatic random_step();
        int                     r;
        int                     delta;
        logic signed [IN_W-1:0] sp;
        logic signed [IN_W-1:0] pv;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            sp = IN_W'($urandom);
            pv = IN_W'($urandom);
        end else if (r < 60) begin
            sp    = IN_W'(int'($urandom_range(0, 4194303)) - 2097152);
            delta = int'($urandom_range(0, 700)) - 350;
            pv    = IN_W'(int'(sp) + delta);
        end else if (r < 80) begin
            sp = IN_W'(int'($urandom_range(0, 2000)) - 1000);
            pv = IN_W'(int'($urandom_range(0, 2000)) - 1000);
        end else begin
            sp = pick_extreme();
            pv = pick_extreme();
        end
        send_step(sp, pv, rand_time_step());
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, long free-running stretches, and one
    // long hold-off on request so that the unit backs up to its input.
    // ------------------------------------------------------------------------
    initial begin : rx_pacing
        int r;
        int span;
        bit lvl;
        bit long_done;
        long_done = 1'b0;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (rx_hold_req && !long_done) begin
                long_done = 1'b1;
                lvl       = 1'b1;
                span      = RX_LONG_HOLD;
            end else if (r < 40) begin
                lvl  = 1'b0;
                span = $urandom_range(1, 300);
            end else if (r < 82) begin
                lvl  = 1'b1;
                span = $urandom_range(1, 4);
            end else if (r < 96) begin
                lvl  = 1'b1;
                span = $urandom_range(5, 40);
            end else begin
                lvl  = 1'b1;
                span = $urandom_range(100, 400);
            end
            out_stall <= lvl;
            repeat (span) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // With the gains still at their reset values the drive is zero, but
        // the integral and the previous error still move.
        send_step(24'sd1000, -24'sd2000, DT_W'(10));
        send_step(IN_MIN, IN_MAX, DT_MAX);
        wait_drained();

        // Moderate gains and a deadband of 100. The write to the spare index
        // must leave every register untouched.
        write_reg(REG_SPARE, '1);
        program_gains(GAIN_W'(3), GAIN_W'(2), GAIN_W'(1), GAIN_W'(1000),
                      GAIN_W'(-5), GAIN_W'(3), GAIN_W'(100));
        send_step('0, '0, DT_W'(1));            // zero error
        send_step(24'sd100, '0, DT_W'(7));      // error on the deadband: no integration
        send_step(-24'sd101, '0, DT_W'(7));     // just beyond it, negative
        send_step(24'sd5, 24'sd5, '0);          // zero time step: no D term, no increment
        send_step(IN_MAX, IN_MIN, DT_W'(1));    // largest positive error
        send_step(IN_MIN, IN_MAX, DT_MAX);      // largest negative error
        send_step(-24'sd1, '0, DT_W'(3));
        wait_drained();

        // Extreme gains with no deadband: most terms saturate on the large errors
        // and the integral wraps.
        program_gains(NUM_MAX, GAIN_W'(1), NUM_MIN, GAIN_W'(1),
                      NUM_MAX, GAIN_W'(1), '0);
        send_step(IN_MAX, IN_MIN, DT_MAX);
        send_step(IN_MIN, IN_MAX, DT_W'(1));
        send_step(IN_MAX, IN_MIN, DT_MAX);
        send_step(24'sd1, '0, DT_W'(1));
        send_step('0, 24'sd1, '0);
        wait_drained();

        // Zero denominators force all three terms to zero.
        program_gains(GAIN_W'(7), '0, GAIN_W'(-3), '0, GAIN_W'(9), '0, DEN_MAX);
        send_step(24'sd1234, -24'sd5678, DT_W'(9));
        send_step(IN_MIN, IN_MAX, DT_MAX);
        wait_drained();

        // Most negative numerators over the largest denominators, deadband 1.
        program_gains(NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX, GAIN_W'(1));
        send_step(IN_MAX, IN_MIN, DT_MAX);
        send_step(24'sd2, 24'sd1, DT_W'(2));
        send_step(-24'sd3, -24'sd1, DT_W'(2));
        send_step(IN_MIN, IN_MAX, DT_W'(1));

        // Random part: a fresh gain setting per phase, reached only once the
        // unit has gone idle.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            random_gains();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // The receiver holds off for a long stretch while steps keep
                // coming, so the output register fills and the input stalls.
                if (ph == 3 && k == 20) begin
                    rx_hold_req <= 1'b1;
                end
                // Mid-phase, the sender waits for every result before going on.
                if (ph == 6 && k == 75) begin
                    wait_drained();
                end
                random_step();
            end
        end

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);

        $display("Checked %0d drive results over %0d gain settings, reset gains included.",
                 result_count, gain_settings);
        $display("Saturation, integral wrap, zero divisors and deadband edges were exercised.");
        if (fail_count == 0) begin
            $display("pid_rational_gain_step_unit regression: pass");
        end else begin
            $display("pid_rational_gain_step_unit regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("pid_rational_gain_step_unit regression: fail");
        $finish;
    end

endmodule
